// File: sv/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
// no dependencies; used by wsd_parser, websocket_frame_deframer and tb_top
package wsd_pkg;

  // width of the decoded length; longer frames are rejected
  localparam int LEN_BITS = 32;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int FLEN_W  = 32;
  localparam int ODATA_W = BYTE_W + FLEN_W;

  // parser phases
  localparam logic [2:0] PH_B0   = 3'd0;
  localparam logic [2:0] PH_B1   = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] K_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] K_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] K_CLOSE = 2'd2;
  localparam logic [KIND_W-1:0] K_ERROR = 2'd3;

  // header field values
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic                  valid;
    logic [KIND_W-1:0]     kind;
    logic [BYTE_W-1:0]     payload_byte;
    logic                  last;
    logic [FLEN_W-1:0]     frame_length;
  } wsd_result_t;

endpackage

// File: sv/wsd_parser.sv
// frame header parser, mask key store and payload unmasking
// depends on wsd_pkg; one byte is consumed per cycle that step_en is high
module wsd_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [wsd_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        restart,
  output wsd_pkg::wsd_result_t        res
);

  logic [2:0]                   phase_r, phase_nxt;
  logic [3:0]                   hdr_cnt_r, hdr_cnt_nxt;
  logic [wsd_pkg::LEN_BITS-1:0] len_acc_r, len_acc_nxt;
  logic [31:0]                  mask_key_r, mask_key_nxt;
  logic [wsd_pkg::LEN_BITS-1:0] remain_r, remain_nxt;
  logic [1:0]                   key_idx_r, key_idx_nxt;
  logic                         halted_r, halted_nxt;

  logic [7:0]  key_byte;
  logic [3:0]  hdr_inc;
  logic [63:0] len_wide;

  assign len_wide = 64'(len_acc_r);
  assign hdr_inc  = hdr_cnt_r + 4'd1;

  always_comb begin
    case (key_idx_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    len_acc_nxt  = len_acc_r;
    mask_key_nxt = mask_key_r;
    remain_nxt   = remain_r;
    key_idx_nxt  = key_idx_r;
    halted_nxt   = halted_r;
    res          = '0;

    if (restart) begin
      phase_nxt    = wsd_pkg::PH_B0;
      hdr_cnt_nxt  = '0;
      len_acc_nxt  = '0;
      mask_key_nxt = '0;
      remain_nxt   = '0;
      key_idx_nxt  = '0;
      halted_nxt   = 1'b0;
    end else if (!halted_r) begin
      case (phase_r)
        wsd_pkg::PH_B0: begin
          if (!data_byte[7]) begin
            halted_nxt = 1'b1;
            res.valid  = 1'b1;
            res.kind   = wsd_pkg::K_ERROR;
          end else if (data_byte[3:0] == wsd_pkg::OP_CLOSE) begin
            halted_nxt = 1'b1;
            res.valid  = 1'b1;
            res.kind   = wsd_pkg::K_CLOSE;
          end else if (data_byte[3:0] != wsd_pkg::OP_TEXT &&
                       data_byte[3:0] != wsd_pkg::OP_BINARY) begin
            halted_nxt = 1'b1;
            res.valid  = 1'b1;
            res.kind   = wsd_pkg::K_ERROR;
          end else begin
            phase_nxt = wsd_pkg::PH_B1;
          end
        end
        wsd_pkg::PH_B1: begin
          if (!data_byte[7]) begin
            halted_nxt = 1'b1;
            res.valid  = 1'b1;
            res.kind   = wsd_pkg::K_ERROR;
          end else if (data_byte[6:0] == wsd_pkg::LEN_CODE16) begin
            len_acc_nxt = '0;
            hdr_cnt_nxt = wsd_pkg::EXT16_BYTES;
            phase_nxt   = wsd_pkg::PH_EXT;
          end else if (data_byte[6:0] == wsd_pkg::LEN_CODE64) begin
            len_acc_nxt = '0;
            hdr_cnt_nxt = wsd_pkg::EXT64_BYTES;
            phase_nxt   = wsd_pkg::PH_EXT;
          end else begin
            len_acc_nxt = wsd_pkg::LEN_BITS'(data_byte[6:0]);
            hdr_cnt_nxt = '0;
            phase_nxt   = wsd_pkg::PH_KEY;
          end
        end
        wsd_pkg::PH_EXT: begin
          // top byte must be clear before another byte shifts in
          if (len_acc_r[wsd_pkg::LEN_BITS-1 -: 8] != 8'd0) begin
            halted_nxt = 1'b1;
            res.valid  = 1'b1;
            res.kind   = wsd_pkg::K_ERROR;
          end else begin
            len_acc_nxt = {len_acc_r[wsd_pkg::LEN_BITS-9:0], data_byte};
            hdr_cnt_nxt = hdr_cnt_r - 4'd1;
            if (hdr_cnt_r == 4'd1) begin
              phase_nxt = wsd_pkg::PH_KEY;
            end
          end
        end
        wsd_pkg::PH_KEY: begin
          mask_key_nxt = {mask_key_r[23:0], data_byte};
          hdr_cnt_nxt  = hdr_inc;
          if (hdr_inc >= wsd_pkg::KEY_BYTES) begin
            hdr_cnt_nxt = '0;
            key_idx_nxt = '0;
            if (len_acc_r == '0) begin
              phase_nxt = wsd_pkg::PH_B0;
              res.valid = 1'b1;
              res.kind  = wsd_pkg::K_EMPTY;
            end else begin
              remain_nxt = len_acc_r;
              phase_nxt  = wsd_pkg::PH_DATA;
            end
          end
        end
        wsd_pkg::PH_DATA: begin
          key_idx_nxt        = key_idx_r + 2'd1;
          remain_nxt         = remain_r - wsd_pkg::LEN_BITS'(1);
          res.valid          = 1'b1;
          res.kind           = wsd_pkg::K_DATA;
          res.payload_byte   = data_byte ^ key_byte;
          res.frame_length   = len_wide[wsd_pkg::FLEN_W-1:0];
          if (remain_r == wsd_pkg::LEN_BITS'(1)) begin
            res.last  = 1'b1;
            phase_nxt = wsd_pkg::PH_B0;
          end
        end
        default: begin
          phase_nxt = wsd_pkg::PH_B0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsd_pkg::PH_B0;
      hdr_cnt_r  <= '0;
      len_acc_r  <= '0;
      mask_key_r <= '0;
      remain_r   <= '0;
      key_idx_r  <= '0;
      halted_r   <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      len_acc_r  <= len_acc_nxt;
      mask_key_r <= mask_key_nxt;
      remain_r   <= remain_nxt;
      key_idx_r  <= key_idx_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

// File: sv/websocket_frame_deframer.sv
// top level of the websocket frame deframer: input register, parser, result register
// depends on wsd_pkg and wsd_parser
//
// usage
//   in channel: one received stream byte per word. in_tdata is the byte,
//   in_tuser[0] is restart, which returns the parser to frame start, clears
//   a halt and drops the byte.
//   out channel: at most one word per input byte. out_tuser gives the kind
//   (payload byte, empty frame done, close seen, protocol error), out_tdata
//   the unmasked payload byte and the decoded frame length, out_tlast marks
//   the final payload byte of a frame.
//   throughput: one byte per cycle unless out_tready stalls a result; each
//   byte is one short step of the header/payload state machine in wsd_parser.
//   path: an accepted byte sits in the input register, is parsed
//   combinationally and its word lands in the result register, which drives
//   the output.
//   reset: rst_n low clears the parser to frame start and empties both
//   registers; the block then takes a byte in the next cycle.
//   stall: while out_tready is low a pending result holds; one more byte can
//   sit in the input register, after which in_tready drops.
//   after a close frame or an error the block reports once and ignores
//   bytes until a restart word arrives.
module websocket_frame_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [wsd_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic [0:0]                   in_tuser,   // [0] restart
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [wsd_pkg::ODATA_W-1:0]  out_tdata,  // [7:0] payload_byte, [39:8] frame_length
  output logic [wsd_pkg::KIND_W-1:0]   out_tuser,  // [1:0] kind
  output logic                         out_tlast   // last payload byte of the frame
);

  // input register
  logic                        s_valid_r;
  logic [wsd_pkg::BYTE_W-1:0]  s_byte_r;
  logic                        s_restart_r;

  // result register
  logic                        o_valid_r;
  logic [wsd_pkg::ODATA_W-1:0] o_data_r;
  logic [wsd_pkg::KIND_W-1:0]  o_kind_r;
  logic                        o_last_r;

  wsd_pkg::wsd_result_t res;
  logic advance;
  logic in_fire;

  // the held byte moves on once the result slot is free or being drained
  assign advance   = s_valid_r && (!o_valid_r || out_tready);
  assign in_tready = !s_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .data_byte (s_byte_r),
    .restart   (s_restart_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_byte_r    <= in_tdata;
      s_restart_r <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance) begin
      o_valid_r <= res.valid;
    end else if (out_tready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      o_data_r <= {res.frame_length, res.payload_byte};
      o_kind_r <= res.kind;
      o_last_r <= res.last;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_data_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for websocket_frame_deframer: directed table, then random frames
// depends on wsd_pkg and the deframer rtl; holds its own frame parser as predictor
module tb_top;
  import wsd_pkg::*;

  // how a directed row is checked: by the predictor or by a result typed into the row
  typedef enum logic [2:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_ERROR,
    ROW_CLOSE,
    ROW_EMPTY
  } row_check_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    row_check_t chk;
  } step_row_t;

  localparam int DIR_ROWS     = 25;
  localparam int RANDOM_WORDS = 1800;
  localparam int PAUSE_EVERY  = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata;
  logic [0:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [ODATA_W-1:0]   out_tdata;
  logic [KIND_W-1:0]    out_tuser;
  logic                 out_tlast;

  websocket_frame_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor: the receive-side frame parser, one step per accepted word
  // ---------------------------------------------------------------------------
  logic [2:0]          dfr_phase;
  logic [3:0]          dfr_hdr_cnt;   // extended length bytes left, then key bytes seen
  logic [LEN_BITS-1:0] dfr_len;
  logic [31:0]         dfr_key;
  logic [LEN_BITS-1:0] dfr_left;
  logic [1:0]          dfr_key_idx;
  logic                dfr_halted;

  function automatic void clear_parser();
    dfr_phase   = PH_B0;
    dfr_hdr_cnt = '0;
    dfr_len     = '0;
    dfr_key     = '0;
    dfr_left    = '0;
    dfr_key_idx = '0;
    dfr_halted  = 1'b0;
  endfunction

  // close and errors report once, then the parser ignores everything until restart
  function automatic wsd_result_t halt_with(input logic [KIND_W-1:0] kind);
    wsd_result_t r;
    r = '0;
    r.valid = 1'b1;
    r.kind = kind;
    dfr_halted = 1'b1;
    return r;
  endfunction

  function automatic wsd_result_t deframe_step(input logic [7:0] b, input logic restart);
    wsd_result_t r;
    logic [7:0]  key_byte;
    r = '0;
    if (restart) begin
      clear_parser();
      return r;
    end
    if (dfr_halted) return r;
    case (dfr_phase)
      PH_B0: begin
        // fin first, then opcode
        if (!b[7]) r = halt_with(K_ERROR);
        else if (b[3:0] == OP_CLOSE) r = halt_with(K_CLOSE);
        else if (b[3:0] != OP_TEXT && b[3:0] != OP_BINARY) r = halt_with(K_ERROR);
        else dfr_phase = PH_B1;
      end
      PH_B1: begin
        // client frames must be masked
        if (!b[7]) begin
          r = halt_with(K_ERROR);
        end else begin
          dfr_len = '0;
          dfr_hdr_cnt = '0;
          if (b[6:0] == LEN_CODE16) begin
            dfr_hdr_cnt = EXT16_BYTES;
            dfr_phase = PH_EXT;
          end else if (b[6:0] == LEN_CODE64) begin
            dfr_hdr_cnt = EXT64_BYTES;
            dfr_phase = PH_EXT;
          end else begin
            dfr_len = LEN_BITS'(b[6:0]);
            dfr_phase = PH_KEY;
          end
        end
      end
      PH_EXT: begin
        // a set bit about to leave the top of the length is a length too wide
        if (dfr_len[LEN_BITS-1 -: 8] != '0) begin
          r = halt_with(K_ERROR);
        end else begin
          dfr_len = {dfr_len[LEN_BITS-9:0], b};
          dfr_hdr_cnt = dfr_hdr_cnt - 4'd1;
          if (dfr_hdr_cnt == '0) dfr_phase = PH_KEY;
        end
      end
      PH_KEY: begin
        dfr_key = {dfr_key[23:0], b};
        dfr_hdr_cnt = dfr_hdr_cnt + 4'd1;
        if (dfr_hdr_cnt == KEY_BYTES) begin
          dfr_hdr_cnt = '0;
          dfr_key_idx = '0;
          if (dfr_len == '0) begin
            // empty frame reports done with zero length
            dfr_phase = PH_B0;
            r.valid = 1'b1;
            r.kind = K_EMPTY;
          end else begin
            dfr_left = dfr_len;
            dfr_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        // key bytes are used most significant first
        key_byte = dfr_key[8 * (3 - dfr_key_idx) +: 8];
        dfr_key_idx = dfr_key_idx + 2'd1;
        dfr_left = dfr_left - 1'b1;
        r.valid = 1'b1;
        r.kind = K_DATA;
        r.payload_byte = b ^ key_byte;
        r.last = (dfr_left == '0);
        r.frame_length = FLEN_W'(dfr_len);
        if (r.last) dfr_phase = PH_B0;
      end
      default: dfr_phase = PH_B0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: predict on input handshake, compare on output handshake
  // ---------------------------------------------------------------------------
  wsd_result_t pending_words [$];
  wsd_result_t mon_pred;
  wsd_result_t mon_want;
  row_check_t  drv_chk;
  row_check_t  next_chk;
  int          n_mismatch;
  int          words_checked;

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
    end else begin
      if (out_tvalid && out_tready) begin
        words_checked++;
        if (pending_words.size() == 0) begin
          $display("%0t unexpected word: kind %0d byte %h last %b length %0d", $time,
                   out_tuser, out_tdata[BYTE_W-1:0], out_tlast, out_tdata[BYTE_W +: FLEN_W]);
          n_mismatch++;
        end else begin
          mon_want = pending_words.pop_front();
          if (out_tuser !== mon_want.kind) begin
            $display("%0t kind: expected %0d, got %0d", $time, mon_want.kind, out_tuser);
            n_mismatch++;
          end
          if (out_tdata[BYTE_W-1:0] !== mon_want.payload_byte) begin
            $display("%0t payload byte: expected %h, got %h", $time,
                     mon_want.payload_byte, out_tdata[BYTE_W-1:0]);
            n_mismatch++;
          end
          if (out_tlast !== mon_want.last) begin
            $display("%0t last: expected %b, got %b", $time, mon_want.last, out_tlast);
            n_mismatch++;
          end
          if (out_tdata[BYTE_W +: FLEN_W] !== mon_want.frame_length) begin
            $display("%0t frame length: expected %0d, got %0d", $time,
                     mon_want.frame_length, out_tdata[BYTE_W +: FLEN_W]);
            n_mismatch++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        // predictor always runs so its state follows the stream
        mon_pred = deframe_step(in_tdata, in_tuser[0]);
        mon_want = '0;
        case (drv_chk)
          ROW_PREDICT: mon_want = mon_pred;
          ROW_QUIET:   mon_want = '0;
          ROW_ERROR:   begin mon_want.valid = 1'b1; mon_want.kind = K_ERROR; end
          ROW_CLOSE:   begin mon_want.valid = 1'b1; mon_want.kind = K_CLOSE; end
          ROW_EMPTY:   begin mon_want.valid = 1'b1; mon_want.kind = K_EMPTY; end
          default:     mon_want = mon_pred;
        endcase
        if (mon_want.valid) pending_words.push_back(mon_want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall before each word, with runs of no stalls
  // ---------------------------------------------------------------------------
  int sink_run;
  bit sink_quiet;

  initial begin
    int stall;
    out_tready = 1'b0;
    sink_run = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (sink_run == 0) begin
        sink_quiet = ($urandom_range(0, 3) == 0);
        sink_run = $urandom_range(10, 80);
      end
      sink_run--;
      stall = sink_quiet ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // stream side
  // ---------------------------------------------------------------------------
  int          src_run;
  bit          src_quiet;
  int          words_sent;
  int          words_ignored;
  int          frames_good;
  int          stops;
  logic [7:0]  frame_q [$];

  // one word: random gap, then hold until taken; valid stays high into the next word
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int gap;
    if (src_run == 0) begin
      src_quiet = ($urandom_range(0, 3) == 0);
      src_run = $urandom_range(10, 80);
    end
    src_run--;
    gap = src_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tuser = restart;
    drv_chk = next_chk;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    words_sent++;
  endtask

  // hold the stream off until every predicted word has come out
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // well-formed masked frame: mostly short payloads, a few long ones,
  // minimal and non-minimal length encodings
  task automatic build_frame(input logic [7:0] head);
    int          sel;
    int          enc;
    logic [31:0] len;
    logic [63:0] ext;
    frame_q.delete();
    sel = $urandom_range(0, 99);
    if (sel < 8) len = 0;
    else if (sel < 70) len = $urandom_range(1, 8);
    else if (sel < 88) len = $urandom_range(9, 40);
    else if (sel < 97) len = $urandom_range(41, 200);
    else len = $urandom_range(201, 600);
    enc = $urandom_range(0, 9);
    frame_q.push_back(head);
    if (len <= 125 && enc < 6) begin
      frame_q.push_back({1'b1, len[6:0]});
    end else if (enc < 9) begin
      frame_q.push_back({1'b1, LEN_CODE16});
      frame_q.push_back(len[15:8]);
      frame_q.push_back(len[7:0]);
    end else begin
      frame_q.push_back({1'b1, LEN_CODE64});
      ext = 64'(len);
      for (int i = 7; i >= 0; i--) frame_q.push_back(ext[8 * i +: 8]);
    end
    repeat (4) frame_q.push_back(8'($urandom));
    repeat (len) frame_q.push_back(8'($urandom));
  endtask

  // bytes after a stop are ignored, then a restart brings the parser back
  task automatic halt_tail();
    repeat ($urandom_range(0, 3)) begin
      send_byte(8'($urandom), 1'b0);
      words_ignored++;
    end
    send_byte(8'($urandom), 1'b1);
    stops++;
  endtask

  task automatic send_frame();
    int         sel;
    int         k;
    logic [7:0] head;
    logic [3:0] op;
    sel = $urandom_range(0, 99);
    head = {1'b1, 3'($urandom), ($urandom_range(0, 1) ? OP_BINARY : OP_TEXT)};
    if (sel < 70) begin
      build_frame(head);
      foreach (frame_q[i]) send_byte(frame_q[i], 1'b0);
      frames_good++;
    end else if (sel < 75) begin
      // close frame
      send_byte({1'b1, 3'($urandom), OP_CLOSE}, 1'b0);
      halt_tail();
    end else if (sel < 80) begin
      // fin clear, any opcode
      send_byte({1'b0, 7'($urandom)}, 1'b0);
      halt_tail();
    end else if (sel < 85) begin
      // unsupported opcode
      do op = 4'($urandom); while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE);
      send_byte({1'b1, 3'($urandom), op}, 1'b0);
      halt_tail();
    end else if (sel < 90) begin
      // mask bit clear
      send_byte(head, 1'b0);
      send_byte({1'b0, 7'($urandom)}, 1'b0);
      halt_tail();
    end else if (sel < 95) begin
      // 64-bit length with a set bit beyond the length width, rejected on the
      // byte that would push it out
      send_byte(head, 1'b0);
      send_byte({1'b1, LEN_CODE64}, 1'b0);
      repeat ($urandom_range(0, 3)) send_byte(8'h00, 1'b0);
      send_byte(8'($urandom_range(1, 255)), 1'b0);
      repeat (4) send_byte(8'($urandom), 1'b0);
      halt_tail();
    end else begin
      // frame cut short by a restart
      build_frame(head);
      k = $urandom_range(1, frame_q.size() - 1);
      for (int i = 0; i < k; i++) send_byte(frame_q[i], 1'b0);
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  step_row_t dir_tab [DIR_ROWS];

  initial begin
    int next_pause;
    int base;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    drv_chk = ROW_PREDICT;
    next_chk = ROW_PREDICT;
    n_mismatch = 0;
    words_checked = 0;
    words_sent = 0;
    words_ignored = 0;
    frames_good = 0;
    stops = 0;
    src_run = 0;
    dir_tab = '{
      '{8'h00, 1'b0, ROW_ERROR},    // first word after reset, fin clear
      '{8'h81, 1'b0, ROW_QUIET},    // halted, ignored
      '{8'hFF, 1'b1, ROW_QUIET},    // restart clears the halt
      '{8'h88, 1'b0, ROW_CLOSE},    // close opcode
      '{8'h00, 1'b1, ROW_QUIET},
      '{8'h8F, 1'b0, ROW_ERROR},    // highest opcode, unsupported
      '{8'h00, 1'b1, ROW_QUIET},
      '{8'h81, 1'b0, ROW_QUIET},    // text
      '{8'h7F, 1'b0, ROW_ERROR},    // mask clear, largest 7-bit code
      '{8'h00, 1'b1, ROW_QUIET},
      '{8'h82, 1'b0, ROW_QUIET},    // binary, empty frame
      '{8'h80, 1'b0, ROW_QUIET},
      '{8'hFF, 1'b0, ROW_QUIET},
      '{8'h00, 1'b0, ROW_QUIET},
      '{8'hFF, 1'b0, ROW_QUIET},
      '{8'h00, 1'b0, ROW_EMPTY},    // last key byte ends the empty frame
      '{8'h81, 1'b0, ROW_QUIET},    // text, 16-bit length of one
      '{8'hFE, 1'b0, ROW_QUIET},
      '{8'h00, 1'b0, ROW_QUIET},
      '{8'h01, 1'b0, ROW_QUIET},
      '{8'h12, 1'b0, ROW_QUIET},
      '{8'h34, 1'b0, ROW_QUIET},
      '{8'h56, 1'b0, ROW_QUIET},
      '{8'h78, 1'b0, ROW_QUIET},
      '{8'hFF, 1'b0, ROW_PREDICT}   // single payload byte, marked last
    };
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      next_chk = dir_tab[i].chk;
      send_byte(dir_tab[i].data_byte, dir_tab[i].restart);
    end
    next_chk = ROW_PREDICT;
    drain_results();

    // random frames, with a full drain every few hundred words
    base = words_sent;
    next_pause = words_sent + PAUSE_EVERY;
    while (words_sent - words_ignored - base < RANDOM_WORDS) begin
      send_frame();
      if (words_sent >= next_pause) begin
        drain_results();
        next_pause = words_sent + PAUSE_EVERY;
      end
    end

    // wait out the pipeline before judging
    drain_results();
    repeat (8) @(negedge clk);
    $display("run covered %0d stream words (%0d ignored while halted), %0d good frames, %0d stops",
             words_sent, words_ignored, frames_good, stops);
    $display("%0d result words compared, %0d mismatches", words_checked, n_mismatch);
    if (n_mismatch == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: websocket_frame_deframer.f
sv/wsd_pkg.sv
sv/wsd_parser.sv
sv/websocket_frame_deframer.sv
tb/sv/tb_top.sv
